>>> rtl/ktcv_pkg.sv
// Shared constants, types and fixed-point helpers for the constant-velocity tracker.
package ktcv_pkg;

  localparam int FracBitsDefault = 16;
  localparam int WordW = 32;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_RATE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROC_NOISE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MEAS_NOISE   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOOKAHEAD    = 3'd4;

  localparam logic [16:0] FramePeriodReset = 17'd2185;
  localparam logic [9:0]  FrameRateReset   = 10'd30;
  localparam logic [30:0] ProcNoiseReset   = 31'd6554;
  localparam logic [30:0] MeasNoiseReset   = 31'd65536;
  localparam logic [7:0]  LookaheadReset   = 8'd5;

  typedef logic signed [WordW-1:0] word_t;

  // Multiplier operation: rounded fixed-point product or plain integer product.
  localparam logic MUL_FIX = 1'b0;
  localparam logic MUL_INT = 1'b1;

  typedef struct packed {
    logic        start;
    logic        mode;
    logic signed [WordW-1:0] a;
    logic signed [WordW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic signed [WordW-1:0] num;
    logic signed [WordW-1:0] den;
  } div_req_t;

  function automatic word_t sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -68'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[WordW-1:0];
  endfunction

endpackage

>>> rtl/ktcv_if.sv
// Valid/ready channel interface carrying one item payload.
interface ktcv_if #(parameter int PayloadW = 64) (input logic clk);
  logic                valid;
  logic                ready;
  logic [PayloadW-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/kalman_tracker_const_velocity_core.sv
// Top level: sequencer, matrix store and shared units of the 2D Kalman tracker.
// The work for each item and each lookahead frame is done by the shared multiplier and the
//   48-step divider, which serve every matrix operation in turn.
// Throughput: one item at a time; in_ch.ready is high only in the idle state.
// The result register holds its item until taken; the next item may be accepted
//   meanwhile, and its result waits in the output state until the register is free.
// Reset (rst, synchronous): state vector zero, covariance identity, last position
//   zero, registers to their defaults (dt 1/30 s, 30 fps, Q 0.1, R 1.0, 5 frames).
module kalman_tracker_const_velocity_core #(
  parameter int FRAC_BITS = ktcv_pkg::FracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  ktcv_if.sink                          in_ch,
  ktcv_if.source                        out_ch,
  input  logic                          cfg_we,
  input  logic [ktcv_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ktcv_pkg::CfgDataW-1:0] cfg_data
);
  import ktcv_pkg::*;
  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0, S_VEL = 5'd1, S_PX = 5'd2, S_AP = 5'd3,
    S_PAT = 5'd4, S_Q = 5'd5, S_LOAD = 5'd6, S_PIV = 5'd7, S_SWAP = 5'd8,
    S_DIV = 5'd9, S_ELIM = 5'd10, S_K = 5'd11, S_INNOV = 5'd12, S_CORR = 5'd13,
    S_IK = 5'd14, S_IKP = 5'd15, S_LA = 5'd16, S_OUT = 5'd17, S_MUL = 5'd18,
    S_DWAIT = 5'd19;

  // Configuration registers.
  logic [16:0] frame_period;
  logic [9:0]  frame_rate;
  logic [30:0] process_noise, measure_noise;
  logic [7:0]  lookahead_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= FramePeriodReset;
      frame_rate <= FrameRateReset;
      process_noise <= ProcNoiseReset;
      measure_noise <= MeasNoiseReset;
      lookahead_frames <= LookaheadReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_PERIOD: frame_period <= cfg_data[16:0];
        CFG_FRAME_RATE:   frame_rate <= cfg_data[9:0];
        CFG_PROC_NOISE:   process_noise <= cfg_data;
        CFG_MEAS_NOISE:   measure_noise <= cfg_data;
        CFG_LOOKAHEAD:    lookahead_frames <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Filter state and scratch matrices.
  word_t xv [4];
  word_t pm [4][4];
  word_t tm [4][4];     // temporary matrix product
  word_t km [4][4];     // gain, then I - K
  word_t am [4][8];     // augmented matrix for the inverse
  word_t zv [4];
  word_t iv [4];
  word_t last_x, last_y, ax, ay;
  logic signed [67:0] acc;

  logic [4:0] state;
  logic [1:0] i, j, k, c, pv, r;
  logic [2:0] kk;
  logic [7:0] la;
  logic [1:0] mop;     // which matrix/vector product is running
  logic       mwait;
  logic       upd_ok;
  word_t      best;

  mul_req_t mreq;
  logic signed [63:0] mprod;
  logic mdone;
  div_req_t dreq;
  word_t dquo;
  logic ddone;

  ktcv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk, .req(mreq), .prod(mprod), .done(mdone));
  ktcv_div #(.FRAC_BITS(FRAC_BITS)) u_div (.clk, .rst, .req(dreq), .quo(dquo), .done(ddone));

  localparam logic [1:0] OP_AP = 2'd0, OP_PAT = 2'd1, OP_K = 2'd2, OP_IKP = 2'd3;

  // A(dt) entry.
  function automatic word_t amat(input logic [1:0] ri, input logic [1:0] ci,
                                 input logic [16:0] dt);
    if (ri == ci) amat = One;
    else if ((ri == 2'd0 && ci == 2'd2) || (ri == 2'd1 && ci == 2'd3))
      amat = word_t'({15'd0, dt});
    else amat = '0;
  endfunction

  word_t abs_a;
  assign abs_a = am[r][c][31] ? -am[r][c] : am[r][c];

  // Operand select for the multiplier.
  always_comb begin
    mreq = '0;
    mreq.mode = MUL_FIX;
    unique case (state)
      S_VEL: begin
        // Use the captured position; the input port may already carry the next item.
        mreq.mode = MUL_INT;
        mreq.a = i[0] ? sat32(68'(zv[1]) - 68'(last_y))
                      : sat32(68'(zv[0]) - 68'(last_x));
        mreq.b = word_t'({22'd0, frame_rate});
      end
      S_PX: begin mreq.a = word_t'({15'd0, frame_period}); mreq.b = xv[i + 2'd2]; end
      S_MUL: begin
        case (mop)
          OP_AP:  begin mreq.a = amat(i, k, frame_period); mreq.b = pm[k][j]; end
          OP_PAT: begin mreq.a = tm[i][k]; mreq.b = amat(j, k, frame_period); end
          OP_K:   begin mreq.a = pm[i][k]; mreq.b = am[k][j + 3'd4]; end
          default: begin mreq.a = km[i][k]; mreq.b = pm[k][j]; end
        endcase
      end
      S_ELIM: begin mreq.a = am[r][c]; mreq.b = am[c][kk]; end
      S_CORR: begin mreq.a = km[i][k]; mreq.b = iv[k]; end
      S_LA: begin
        mreq.a = word_t'({15'd0, frame_period});
        mreq.b = i[0] ? xv[3] : xv[2];
      end
      default: ;
    endcase
    mreq.start = !mwait && (state == S_VEL || state == S_PX || state == S_MUL ||
      state == S_ELIM || state == S_CORR || (state == S_LA && la != '0));
  end

  always_comb begin
    dreq.start = (state == S_DIV) && !mwait;
    dreq.num = am[c][kk];
    dreq.den = am[c][c];
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      mwait <= 1'b0;
      for (int a = 0; a < 4; a++) begin
        xv[a] <= '0;
        for (int b = 0; b < 4; b++) pm[a][b] <= (a == b) ? One : '0;
      end
      last_x <= '0;
      last_y <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_OUT) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          // Take the item; velocity measure first.
          zv[0] <= in_ch.payload[31:0];
          zv[1] <= in_ch.payload[63:32];
          i <= '0; mwait <= 1'b0; state <= S_VEL;
        end
        S_VEL: if (!mwait) mwait <= 1'b1; else if (mdone) begin
          mwait <= 1'b0;
          zv[2 + i] <= sat32(68'(mprod));
          if (i == 2'd1) begin i <= '0; state <= S_PX; end else i <= i + 1'b1;
        end
        S_PX: if (!mwait) mwait <= 1'b1; else if (mdone) begin
          mwait <= 1'b0;
          xv[i] <= sat32(68'(xv[i]) + 68'(mprod));
          if (i == 2'd1) begin
            i <= '0; j <= '0; k <= '0; acc <= '0; mop <= OP_AP; state <= S_MUL;
          end else i <= i + 1'b1;
        end
        S_MUL: if (!mwait) mwait <= 1'b1; else if (mdone) begin
          // Accumulate one product of a 4x4 by 4x4 product; step k, j, i.
          mwait <= 1'b0;
          if (k != 2'd3) begin
            acc <= acc + 68'(mprod); k <= k + 1'b1;
          end else begin
            acc <= '0; k <= '0;
            case (mop)
              OP_K: km[i][j] <= sat32(acc + 68'(mprod));
              OP_PAT: pm[i][j] <= sat32(acc + 68'(mprod));
              default: tm[i][j] <= sat32(acc + 68'(mprod));
            endcase
            if (j != 2'd3) j <= j + 1'b1;
            else begin
              j <= '0;
              if (i != 2'd3) i <= i + 1'b1;
              else begin
                i <= '0;
                case (mop)
                  OP_AP: mop <= OP_PAT;
                  OP_PAT: state <= S_Q;
                  OP_K: state <= S_INNOV;
                  default: state <= S_LA;
                endcase
              end
            end
          end
        end
        S_Q: begin
          for (int a = 0; a < 4; a++)
            pm[a][a] <= sat32(68'(pm[a][a]) + 68'({1'b0, process_noise}));
          state <= S_LOAD;
        end
        S_LOAD: begin
          for (int a = 0; a < 4; a++) for (int b = 0; b < 8; b++)
            if (b < 4) am[a][b] <= (a == b) ?
              sat32(68'(pm[a][b]) + 68'({1'b0, measure_noise})) : pm[a][b];
            else am[a][b] <= (b - 4 == a) ? One : '0;
          c <= '0; upd_ok <= 1'b1; state <= S_PIV;
          r <= '0;
        end
        S_PIV: begin
          // Scan rows c..3 for the first largest magnitude, one row a cycle.
          if (r == c) begin best <= abs_a; pv <= c; end
          else if ($unsigned(abs_a) > $unsigned(best)) begin best <= abs_a; pv <= r; end
          if (r == 2'd3) state <= S_SWAP; else r <= r + 1'b1;
        end
        S_SWAP: begin
          if (best == '0) begin upd_ok <= 1'b0; la <= lookahead_frames;
            ax <= xv[0]; ay <= xv[1]; i <= '0; state <= S_LA;
          end else begin
            for (int b = 0; b < 8; b++) begin
              am[pv][b] <= am[c][b];
              am[c][b] <= am[pv][b];
            end
            kk <= 3'd7; state <= S_DIV;
          end
        end
        S_DIV: if (!mwait) mwait <= 1'b1; else if (ddone) begin
          // Divide the pivot row from the right so the pivot itself goes last.
          mwait <= 1'b0;
          am[c][kk] <= dquo;
          if (kk == 3'({1'b0, c})) begin r <= (c == 2'd0) ? 2'd1 : 2'd0;
            kk <= (c == 2'd0) ? 3'd1 : 3'd0;
            state <= S_ELIM;
          end else if (kk == 3'd0) kk <= 3'({1'b0, c});
          else if (kk - 1'b1 == 3'({1'b0, c})) kk <= (c == 2'd0) ? 3'd0 : kk - 3'd2;
          else kk <= kk - 1'b1;
        end
        S_ELIM: if (!mwait) mwait <= 1'b1; else if (mdone) begin
          // Column c of row r is read last since it is the factor.
          mwait <= 1'b0;
          am[r][kk] <= sat32(68'(am[r][kk]) - 68'(mprod));
          if (kk == 3'({1'b0, c})) begin
            kk <= (c == 2'd0) ? 3'd1 : 3'd0;
            if (r == 2'd3 || (r == 2'd2 && c == 2'd3)) begin
              if (c == 2'd3) begin
                i <= '0; j <= '0; k <= '0; acc <= '0; mop <= OP_K; state <= S_MUL;
              end else begin c <= c + 1'b1; r <= c + 1'b1; state <= S_PIV; end
            end else r <= (r + 1'b1 == c) ? r + 2'd2 : r + 1'b1;
          end else if (kk == 3'd7) kk <= 3'({1'b0, c});
          else if (kk + 1'b1 == 3'({1'b0, c})) kk <= kk + 3'd2;
          else kk <= kk + 1'b1;
        end
        S_INNOV: begin
          for (int a = 0; a < 4; a++) iv[a] <= sat32(68'(zv[a]) - 68'(xv[a]));
          i <= '0; k <= '0; acc <= '0; state <= S_CORR;
        end
        S_CORR: if (!mwait) mwait <= 1'b1; else if (mdone) begin
          mwait <= 1'b0;
          if (k != 2'd3) begin acc <= acc + 68'(mprod); k <= k + 1'b1; end
          else begin
            acc <= '0; k <= '0;
            tm[i][0] <= sat32(68'(xv[i]) + 68'(sat32(acc + 68'(mprod))));
            if (i == 2'd3) state <= S_IK; else i <= i + 1'b1;
          end
        end
        S_IK: begin
          for (int a = 0; a < 4; a++) begin
            xv[a] <= tm[a][0];
            for (int b = 0; b < 4; b++)
              km[a][b] <= sat32(((a == b) ? 68'(One) : 68'sd0) - 68'(km[a][b]));
          end
          i <= '0; j <= '0; k <= '0; acc <= '0; mop <= OP_IKP; state <= S_MUL;
          la <= lookahead_frames;
        end
        S_LA: begin
          if (mop == OP_IKP && upd_ok) begin ax <= xv[0]; ay <= xv[1]; mop <= OP_AP;
            // Commit the updated covariance held in the scratch matrix.
            for (int a = 0; a < 4; a++) for (int b = 0; b < 4; b++) pm[a][b] <= tm[a][b];
            la <= lookahead_frames; i <= '0;
          end else if (la == '0) state <= S_OUT;
          else if (!mwait) mwait <= 1'b1;
          else if (mdone) begin
            mwait <= 1'b0;
            if (i[0]) begin ay <= sat32(68'(ay) + 68'(mprod)); la <= la - 1'b1; i <= '0; end
            else begin ax <= sat32(68'(ax) + 68'(mprod)); i <= 2'd1; end
          end
        end
        S_OUT: if (!out_ch.valid || out_ch.ready) begin
          // Hold here while the previous result still waits in the output register.
          last_x <= zv[0]; last_y <= zv[1];
          out_ch.payload <= {ay, ax, xv[3], xv[2], xv[1], xv[0]};
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The block takes an item only in the idle state.
  assert property (@(posedge clk) disable iff (rst) in_ch.ready |-> state == S_IDLE)
    else $error("ready outside idle");
  // A result appears only from the output state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_OUT) else $error("stray result");
  // A waiting result holds until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.payload))
    else $error("result changed while stalled");
endmodule

>>> rtl/ktcv_mul.sv
// Shared multiplier: registered 32x32 product with rounding shift or plain mode.
module ktcv_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  ktcv_pkg::mul_req_t    req,
  output logic signed [63:0]    prod,
  output logic                  done
);
  import ktcv_pkg::*;
  logic signed [63:0] raw;
  logic               mode_q;
  logic               busy;
  logic signed [64:0] rnd;

  always_ff @(posedge clk) begin
    raw    <= 64'(req.a) * 64'(req.b);
    mode_q <= req.mode;
    busy   <= req.start;
    done   <= busy;
  end

  // Round half up: add half LSB, floor shift.
  assign rnd = 65'(raw) + (65'sd1 <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (mode_q == MUL_INT) prod <= raw;
    else prod <= 64'(rnd >>> FRAC_BITS);
  end
endmodule

>>> rtl/ktcv_div.sv
// Restoring divider: saturated (num << FRAC_BITS) / den, truncated toward zero.
module ktcv_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ktcv_pkg::div_req_t req,
  output ktcv_pkg::word_t    quo,
  output logic               done
);
  import ktcv_pkg::*;
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] rem_num;
  logic [NW-1:0] q;
  logic [NW:0]   r;
  logic [31:0]   d;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NW:0]   r_sh;
  logic signed [67:0] sq;

  assign r_sh = {r[NW-1:0], rem_num[NW-1]};
  assign sq = neg ? -68'($unsigned(q)) : 68'($unsigned(q));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        rem_num <= NW'(req.num[31] ? -64'(req.num) : 64'(req.num)) << FRAC_BITS;
        d       <= req.den[31] ? 32'(-33'(req.den)) : 32'(req.den);
        neg     <= req.num[31] ^ req.den[31];
        r       <= '0;
        q       <= '0;
        cnt     <= CW'(NW);
      end else if (busy) begin
        rem_num <= rem_num << 1;
        if (r_sh >= {{(NW-31){1'b0}}, d}) begin
          r <= r_sh - {{(NW-31){1'b0}}, d};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          r <= r_sh;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = sat32(sq);
endmodule
